@@ rtl/hh4d_pkg.sv @@
package hh4d_pkg;

	localparam int unsigned CAP_W   = 17;
	localparam int unsigned HDR_MAX = 5;
	localparam int unsigned IDX_W   = 3;

	localparam logic [CAP_W-1:0] CAP_RESET    = 17'd1024;
	localparam logic [15:0]      ISO_LEN_MASK = 16'h3fff;

	localparam logic [7:0] TYPE_CMD   = 8'd1;
	localparam logic [7:0] TYPE_ACL   = 8'd2;
	localparam logic [7:0] TYPE_SCO   = 8'd3;
	localparam logic [7:0] TYPE_EVENT = 8'd4;
	localparam logic [7:0] TYPE_ISO   = 8'd5;

	typedef logic [HDR_MAX-1:0][7:0] hdr_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] packet_kind;
		logic       first_of_packet;
		logic       last_of_packet;
		logic       stream_error;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic             burst;
		result_t          res;
		logic [IDX_W-1:0] end_idx;
		logic             pay_zero;
	} load_t;

	// header length including the type byte; zero for an unknown type
	function automatic logic [IDX_W-1:0] hdr_len(input logic [7:0] t);
		logic [IDX_W-1:0] len;
		unique case (t)
			TYPE_CMD:   len = 3'd4;
			TYPE_ACL:   len = 3'd5;
			TYPE_SCO:   len = 3'd4;
			TYPE_EVENT: len = 3'd3;
			TYPE_ISO:   len = 3'd5;
			default:    len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/hh4d_byte_if.sv @@
interface hh4d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

@@ rtl/hh4d_result_if.sv @@
interface hh4d_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] packet_kind;
	logic       first_of_packet;
	logic       last_of_packet;
	logic       stream_error;

	modport source (output valid, output out_byte, output packet_kind,
		output first_of_packet, output last_of_packet, output stream_error, input ready);
	modport sink (input valid, input out_byte, input packet_kind,
		input first_of_packet, input last_of_packet, input stream_error, output ready);
endinterface

@@ rtl/hh4d_cfg_if.sv @@
interface hh4d_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] max_packet_bytes;

	modport source (output valid, output max_packet_bytes, input ready);
	modport sink (input valid, input max_packet_bytes, output ready);
endinterface

@@ rtl/hh4d_emitter.sv @@
module hh4d_emitter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hh4d_pkg::load_t       load,
	input  hh4d_pkg::hdr_t        hdr,
	output logic                  can_load,
	hh4d_result_if.source         res_ch
);

	logic                           vld_q;
	logic                           burst_q;
	logic [hh4d_pkg::IDX_W-1:0]     idx_q;
	logic [hh4d_pkg::IDX_W-1:0]     end_q;
	logic                           payz_q;
	hh4d_pkg::result_t              res_q;
	logic                           final_beat;
	logic                           beat_done;

	assign final_beat = !burst_q || (idx_q == end_q);
	assign beat_done  = vld_q && res_ch.ready;
	assign can_load   = !vld_q || (res_ch.ready && final_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			burst_q <= 1'b0;
			idx_q   <= '0;
		end else if (load.valid) begin
			vld_q   <= 1'b1;
			burst_q <= load.burst;
			idx_q   <= '0;
		end else if (beat_done) begin
			if (final_beat) begin
				vld_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid) begin
			res_q  <= load.res;
			end_q  <= load.end_idx;
			payz_q <= load.pay_zero;
		end
	end

	always_comb begin
		res_ch.valid = vld_q;
		if (burst_q) begin
			// release held header bytes, one per beat
			res_ch.out_byte        = hdr[idx_q];
			res_ch.packet_kind     = hdr[0][2:0];
			res_ch.first_of_packet = (idx_q == '0);
			res_ch.last_of_packet  = payz_q && (idx_q == end_q);
			res_ch.stream_error    = 1'b0;
		end else begin
			res_ch.out_byte        = res_q.out_byte;
			res_ch.packet_kind     = res_q.packet_kind;
			res_ch.first_of_packet = res_q.first_of_packet;
			res_ch.last_of_packet  = res_q.last_of_packet;
			res_ch.stream_error    = res_q.stream_error;
		end
	end

endmodule

@@ rtl/hci_h4_packet_deframer_core.sv @@
// A request that yields results shows its first result in the cycle after acceptance.
// One input byte is taken per cycle while each yields at most one result and the sink
// is ready; a byte that completes a header releases up to five results, one per cycle
// while the sink is ready, and the next byte is taken as the last of them leaves. The
// result register sets this rate. Reset (arst_n low): clears parse state, the sticky
// failure and the output stage; max_packet_bytes returns to 1024. Held header bytes are not cleared.
module hci_h4_packet_deframer_core (
	input  logic           clk,
	input  logic           arst_n,
	hh4d_byte_if.sink      in_ch,
	hh4d_cfg_if.sink       cfg_ch,
	hh4d_result_if.source  res_ch
);

	hh4d_pkg::hdr_t                    hs_q;
	logic [hh4d_pkg::CAP_W-1:0]        taken_q;
	logic [hh4d_pkg::CAP_W-1:0]        exp_q;
	logic                              inh_q;
	logic                              failed_q;
	logic [hh4d_pkg::CAP_W-1:0]        max_q;

	logic                              can_load;
	logic                              acc;
	logic [7:0]                        b;
	logic                              start;
	logic [hh4d_pkg::IDX_W-1:0]        hl;
	logic [hh4d_pkg::CAP_W-1:0]        exp_eff;
	logic                              inh_eff;
	logic                              bad_type;
	hh4d_pkg::hdr_t                    hs_n;
	logic [hh4d_pkg::CAP_W-1:0]        taken1;
	logic                              hdr_done;
	logic [15:0]                       payload;
	logic [hh4d_pkg::CAP_W-1:0]        total;
	logic                              too_big;
	logic                              pay_last;
	logic                              pay_zero;

	hh4d_pkg::load_t                   load;
	logic [hh4d_pkg::CAP_W-1:0]        taken_d;
	logic [hh4d_pkg::CAP_W-1:0]        exp_d;
	logic                              inh_d;
	logic                              failed_d;
	logic                              hs_we;

	assign in_ch.ready  = can_load;
	assign acc          = in_ch.valid && can_load;
	assign cfg_ch.ready = 1'b1;

	assign b        = in_ch.byte_in;
	assign start    = (taken_q == '0);
	assign hl       = hh4d_pkg::hdr_len(b);
	assign exp_eff  = start ? {14'd0, hl} : exp_q;
	assign inh_eff  = start || inh_q;
	assign bad_type = start && ((hl == '0) || ({14'd0, hl} > max_q));
	assign taken1   = taken_q + 17'd1;
	assign hdr_done = (taken1 >= exp_eff);
	assign pay_last = (taken1 >= exp_q);

	always_comb begin
		for (int i = 0; i < hh4d_pkg::HDR_MAX; i++) begin
			hs_n[i] = (taken_q == 17'(i)) ? b : hs_q[i];
		end
	end

	// payload length from the header as it stands with this byte included
	always_comb begin
		priority if (hs_n[0] == hh4d_pkg::TYPE_ISO) begin
			payload = {hs_n[4], hs_n[3]} & hh4d_pkg::ISO_LEN_MASK;
		end else if (hs_n[0] == hh4d_pkg::TYPE_ACL) begin
			payload = {hs_n[4], hs_n[3]};
		end else if (hs_n[0] == hh4d_pkg::TYPE_EVENT) begin
			payload = {8'd0, hs_n[2]};
		end else begin
			payload = {8'd0, hs_n[3]};
		end
	end

	assign total    = exp_eff + {1'b0, payload};
	assign too_big  = (total > max_q);
	assign pay_zero = (payload == '0);

	always_comb begin
		load     = '0;
		taken_d  = taken_q;
		exp_d    = exp_q;
		inh_d    = inh_q;
		failed_d = failed_q;
		hs_we    = 1'b0;
		if (acc) begin
			priority if (failed_q || bad_type) begin
				failed_d                = 1'b1;
				load.valid              = 1'b1;
				load.res.stream_error   = 1'b1;
			end else if (inh_eff) begin
				hs_we = 1'b1;
				priority if (!hdr_done) begin
					taken_d = taken1;
					exp_d   = exp_eff;
					inh_d   = 1'b1;
				end else if (too_big) begin
					failed_d              = 1'b1;
					load.valid            = 1'b1;
					load.res.stream_error = 1'b1;
				end else begin
					// release the whole header
					load.valid    = 1'b1;
					load.burst    = 1'b1;
					load.end_idx  = exp_eff[hh4d_pkg::IDX_W-1:0] - 3'd1;
					load.pay_zero = pay_zero;
					exp_d         = total;
					taken_d       = pay_zero ? '0 : taken1;
					inh_d         = 1'b0;
				end
			end else begin
				// pass payload byte through
				load.valid                = 1'b1;
				load.res.out_byte         = b;
				load.res.packet_kind      = hs_q[0][2:0];
				load.res.last_of_packet   = pay_last;
				taken_d                   = pay_last ? '0 : taken1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q  <= '0;
			exp_q    <= '0;
			inh_q    <= 1'b0;
			failed_q <= 1'b0;
			max_q    <= hh4d_pkg::CAP_RESET;
		end else begin
			taken_q  <= taken_d;
			exp_q    <= exp_d;
			inh_q    <= inh_d;
			failed_q <= failed_d;
			if (cfg_ch.valid) begin
				max_q <= cfg_ch.max_packet_bytes;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hs_we) begin
			hs_q <= hs_n;
		end
	end

	hh4d_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.hdr      (hs_q),
		.can_load (can_load),
		.res_ch   (res_ch)
	);

endmodule
